### rtl/ksq_pkg.sv
// ksq_pkg: shared constants for the k-queues shared-buffer block.
// No dependencies; used by the other files under rtl/ and by the testbench.
`default_nettype none

package ksq_pkg;

  localparam int DEPTH_DEF  = 16;
  localparam int QUEUES_DEF = 4;

  localparam int DATA_W   = 32;
  localparam int QID_W    = 2;
  localparam int STATUS_W = 2;

  localparam logic ACT_ENQ = 1'b0;
  localparam logic ACT_DEQ = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVER  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNDER = 2'd2;

endpackage

`default_nettype wire

### rtl/ksq_store.sv
// ksq_store: data and next-link memories, one registered read port and one write port each.
// Depends on ksq_pkg for the data width.
`default_nettype none

module ksq_store #(
  parameter int DEPTH = ksq_pkg::DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH),
  parameter int PW    = $clog2(DEPTH + 1)
) (
  input  wire logic                       clk,
  input  wire logic                       rd_en,
  input  wire logic [AW-1:0]              link_rd_addr,
  input  wire logic [AW-1:0]              data_rd_addr,
  output logic      [PW-1:0]              link_rdata,
  output logic      [ksq_pkg::DATA_W-1:0] data_rdata,
  input  wire logic                       link_we,
  input  wire logic [AW-1:0]              link_wr_addr,
  input  wire logic [PW-1:0]              link_wr_data,
  input  wire logic                       data_we,
  input  wire logic [AW-1:0]              data_wr_addr,
  input  wire logic [ksq_pkg::DATA_W-1:0] data_wr_data
);

  logic [PW-1:0]              link_mem [DEPTH];
  logic [ksq_pkg::DATA_W-1:0] data_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_wr_addr] <= link_wr_data;
    end
    if (rd_en) begin
      link_rdata <= link_mem[link_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (data_we) begin
      data_mem[data_wr_addr] <= data_wr_data;
    end
    if (rd_en) begin
      data_rdata <= data_mem[data_rd_addr];
    end
  end

endmodule

`default_nettype wire

### rtl/k_queues_shared_buffer.sv
// k_queues_shared_buffer: QUEUES FIFOs sharing one DEPTH-entry store via a free list.
// Timing: a taken start sets busy_r, then out_valid_r gives the result strobe.
// No start is taken while busy: link memory read (registered), then pointer update and write.
// busy is high for the cycle between; the receiver cannot stall.
// Reset (sync, rst_n low): all queues empty, free list 0..DEPTH-1; a fill count stands
// in for the link reset, so there is no clearing pass. Depends on ksq_pkg, ksq_store.
`default_nettype none

module k_queues_shared_buffer #(
  parameter int DEPTH  = ksq_pkg::DEPTH_DEF,
  parameter int QUEUES = ksq_pkg::QUEUES_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic                         in_action,
  input  wire logic [ksq_pkg::QID_W-1:0]    in_queue_id,
  input  wire logic [ksq_pkg::DATA_W-1:0]   in_push_value,
  output logic                              out_valid,
  output logic [ksq_pkg::DATA_W-1:0]        out_pop_value,
  output logic [ksq_pkg::STATUS_W-1:0]      out_status
);

  localparam int AW  = $clog2(DEPTH);
  localparam int PW  = $clog2(DEPTH + 1);
  localparam int QIW = (QUEUES > 1) ? $clog2(QUEUES) : 1;
  localparam logic [PW-1:0] NIL = PW'(DEPTH);

  logic [PW-1:0] head_r [QUEUES];
  logic [PW-1:0] tail_r [QUEUES];
  logic [PW-1:0] free_head_r, free_head_nxt;
  logic [PW-1:0] fresh_r, fresh_nxt;

  logic                       busy_r;
  logic                       op_act_r;
  logic [QIW-1:0]             op_q_r;
  logic                       op_qok_r;
  logic [ksq_pkg::DATA_W-1:0] op_word_r;
  logic [PW-1:0]              op_head_r;
  logic [PW-1:0]              op_tail_r;

  logic                       out_valid_r;
  logic [ksq_pkg::DATA_W-1:0] out_pop_value_r, out_pop_value_nxt;
  logic [ksq_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;

  logic                       accept;
  logic [QIW-1:0]             in_qi;
  logic                       in_qok;
  logic [PW-1:0]              rd_head;

  logic [PW-1:0]              link_rdata;
  logic [ksq_pkg::DATA_W-1:0] data_rdata;
  logic                       link_we, data_we;
  logic [PW-1:0]              link_wr_ptr, link_wr_data;

  logic                       fh_ok, h_ok, fh_fresh, q_last;
  logic                       enq_ok, deq_ok;
  logic                       hd_we, tl_we;
  logic [PW-1:0]              hd_wdata, tl_wdata;

  assign accept  = start && !busy_r;
  assign in_qi   = QIW'(in_queue_id);
  assign in_qok  = 32'(in_queue_id) < QUEUES;
  assign rd_head = head_r[in_qi];

  ksq_store #(.DEPTH(DEPTH), .AW(AW), .PW(PW)) u_store (
    .clk          (clk),
    .rd_en        (accept),
    .link_rd_addr ((in_action == ksq_pkg::ACT_DEQ) ? rd_head[AW-1:0] : free_head_r[AW-1:0]),
    .data_rd_addr (rd_head[AW-1:0]),
    .link_rdata   (link_rdata),
    .data_rdata   (data_rdata),
    .link_we      (link_we),
    .link_wr_addr (link_wr_ptr[AW-1:0]),
    .link_wr_data (link_wr_data),
    .data_we      (data_we),
    .data_wr_addr (free_head_r[AW-1:0]),
    .data_wr_data (op_word_r)
  );

  // entries at or above fresh_r were never allocated; their link is simply the next entry
  always_comb begin
    fh_ok    = free_head_r < NIL;
    h_ok     = op_head_r < NIL;
    fh_fresh = free_head_r == fresh_r;
    q_last   = op_head_r == op_tail_r;
    enq_ok   = busy_r && (op_act_r == ksq_pkg::ACT_ENQ) && op_qok_r && fh_ok;
    deq_ok   = busy_r && (op_act_r == ksq_pkg::ACT_DEQ) && op_qok_r && h_ok;

    free_head_nxt     = free_head_r;
    fresh_nxt         = fresh_r;
    link_we           = 1'b0;
    link_wr_ptr       = op_tail_r;
    link_wr_data      = free_head_r;
    data_we           = 1'b0;
    hd_we             = 1'b0;
    hd_wdata          = free_head_r;
    tl_we             = 1'b0;
    tl_wdata          = free_head_r;
    out_pop_value_nxt = '0;
    out_status_nxt    = ksq_pkg::ST_OK;

    if (enq_ok) begin
      free_head_nxt = fh_fresh ? PW'(free_head_r + PW'(1)) : link_rdata;
      fresh_nxt     = fh_fresh ? PW'(fresh_r + PW'(1)) : fresh_r;
      link_we       = h_ok;
      hd_we         = !h_ok;
      tl_we         = 1'b1;
      data_we       = 1'b1;
    end else if (deq_ok) begin
      hd_we             = 1'b1;
      hd_wdata          = q_last ? NIL : link_rdata;
      tl_we             = q_last;
      tl_wdata          = NIL;
      link_we           = 1'b1;
      link_wr_ptr       = op_head_r;
      link_wr_data      = free_head_r;
      free_head_nxt     = op_head_r;
      out_pop_value_nxt = data_rdata;
    end else if (op_act_r == ksq_pkg::ACT_DEQ) begin
      out_status_nxt = ksq_pkg::ST_UNDER;
    end else begin
      out_status_nxt = ksq_pkg::ST_OVER;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      free_head_r <= '0;
      fresh_r     <= '0;
      for (int i = 0; i < QUEUES; i++) begin
        head_r[i] <= NIL;
        tail_r[i] <= NIL;
      end
    end else begin
      busy_r      <= accept;
      out_valid_r <= busy_r;
      if (busy_r) begin
        free_head_r <= free_head_nxt;
        fresh_r     <= fresh_nxt;
        if (hd_we) begin
          head_r[op_q_r] <= hd_wdata;
        end
        if (tl_we) begin
          tail_r[op_q_r] <= tl_wdata;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_act_r  <= in_action;
      op_q_r    <= in_qi;
      op_qok_r  <= in_qok;
      op_word_r <= in_push_value;
      op_head_r <= rd_head;
      op_tail_r <= tail_r[in_qi];
    end
    if (busy_r) begin
      out_pop_value_r <= out_pop_value_nxt;
      out_status_r    <= out_status_nxt;
    end
  end

  assign busy          = busy_r;
  assign out_valid     = out_valid_r;
  assign out_pop_value = out_pop_value_r;
  assign out_status    = out_status_r;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after start");

  a_busy_result: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> out_valid && !busy)
    else $error("result strobe missing after busy cycle");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ksq_pkg::ST_OK) |-> out_pop_value == '0)
    else $error("nonzero word on failed operation");

  a_full_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (free_head_r == NIL) |-> (fresh_r == NIL))
    else $error("free list empty before all entries allocated");

endmodule

`default_nettype wire

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// testbench: self-checking bench for k_queues_shared_buffer (four FIFOs sharing one store).
// A queue-fed driver and a strobe monitor, with an in-order linked-list predictor.
// Depends on ksq_pkg and the k_queues_shared_buffer RTL.

module testbench;

  localparam int DEPTH    = ksq_pkg::DEPTH_DEF;
  localparam int QUEUES   = ksq_pkg::QUEUES_DEF;
  localparam int DATA_W   = ksq_pkg::DATA_W;
  localparam int QID_W    = ksq_pkg::QID_W;
  localparam int STATUS_W = ksq_pkg::STATUS_W;
  localparam int PTR_W  = $clog2(DEPTH) + 1;
  localparam logic [PTR_W-1:0] NIL = PTR_W'(DEPTH);
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_WORDS = 357;

  typedef struct packed {
    logic              action;
    logic [QID_W-1:0]  queue_id;
    logic [DATA_W-1:0] push_value;
  } queue_op_t;

  typedef struct packed {
    logic [DATA_W-1:0]   pop_value;
    logic [STATUS_W-1:0] status;
  } queue_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic in_action = ksq_pkg::ACT_ENQ;
  logic [QID_W-1:0] in_queue_id = '0;
  logic [DATA_W-1:0] in_push_value = '0;
  logic busy;
  logic out_valid;
  logic [DATA_W-1:0] out_pop_value;
  logic [STATUS_W-1:0] out_status;

  k_queues_shared_buffer uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_action    (in_action),
    .in_queue_id  (in_queue_id),
    .in_push_value(in_push_value),
    .out_valid    (out_valid),
    .out_pop_value(out_pop_value),
    .out_status   (out_status)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  logic [DATA_W-1:0] word_mem [DEPTH];
  logic [PTR_W-1:0]  next_link [DEPTH];
  logic [PTR_W-1:0]  q_head [QUEUES];
  logic [PTR_W-1:0]  q_tail [QUEUES];
  logic [PTR_W-1:0]  free_top;

  queue_op_t     pending_ops[$];
  queue_result_t expected_results[$];
  queue_op_t     driven_op;
  queue_result_t got_result, want_result;
  int idle_pct = 0;
  int errors = 0;
  int cycles = 0;
  int words_taken = 0;
  int n_ok = 0, n_over = 0, n_under = 0;

  function automatic bit is_entry(logic [PTR_W-1:0] p);
    return p < DEPTH;
  endfunction

  task automatic clear_queues();
    for (int i = 0; i < DEPTH; i++) begin
      word_mem[i]  = '0;
      next_link[i] = (i == DEPTH - 1) ? NIL : PTR_W'(i + 1);
    end
    for (int i = 0; i < QUEUES; i++) begin
      q_head[i] = NIL;
      q_tail[i] = NIL;
    end
    free_top = '0;
  endtask

  function automatic queue_result_t apply_op(queue_op_t op);
    queue_result_t r;
    logic [PTR_W-1:0] slot, nxt;
    int q;
    q = op.queue_id;
    r.pop_value = '0;
    r.status = ksq_pkg::ST_OK;
    if (op.action == ksq_pkg::ACT_ENQ) begin
      if (q >= QUEUES || !is_entry(free_top)) begin
        r.status = ksq_pkg::ST_OVER;
      end else begin
        slot = free_top;
        free_top = next_link[slot];
        if (!is_entry(q_head[q]) || !is_entry(q_tail[q])) q_head[q] = slot;
        else next_link[q_tail[q]] = slot;
        next_link[slot] = NIL;
        q_tail[q] = slot;
        word_mem[slot] = op.push_value;
      end
    end else begin
      if (q >= QUEUES || !is_entry(q_head[q])) begin
        r.status = ksq_pkg::ST_UNDER;
      end else begin
        slot = q_head[q];
        nxt = next_link[slot];
        if (!is_entry(nxt)) begin
          q_head[q] = NIL;
          q_tail[q] = NIL;
        end else begin
          q_head[q] = nxt;
        end
        next_link[slot] = is_entry(free_top) ? free_top : NIL;
        free_top = slot;
        r.pop_value = word_mem[slot];
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    $display("MISMATCH @%0d: %s got %h want %h", cycles, what, got, want);
    errors++;
  endtask

  function automatic logic [DATA_W-1:0] pick_word();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_op(input logic act, input int q, input logic [DATA_W-1:0] w);
    queue_op_t op;
    op.action = act;
    op.queue_id = QID_W'(q);
    op.push_value = w;
    pending_ops.push_back(op);
  endtask

  task automatic drain_all();
    while (pending_ops.size() != 0 || start || expected_results.size() != 0)
      @(negedge clk);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_results.push_back(apply_op(driven_op));
        words_taken++;
      end
      if (!start || !busy) begin
        if (pending_ops.size() != 0 && $urandom_range(99) >= idle_pct) begin
          driven_op = pending_ops.pop_front();
          start <= 1'b1;
          in_action <= driven_op.action;
          in_queue_id <= driven_op.queue_id;
          in_push_value <= driven_op.push_value;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      got_result.pop_value = out_pop_value;
      got_result.status = out_status;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result word", got_result.pop_value, '0);
      end else begin
        want_result = expected_results.pop_front();
        if (got_result.status !== want_result.status)
          report_mismatch("status", DATA_W'(got_result.status), DATA_W'(want_result.status));
        if (got_result.pop_value !== want_result.pop_value)
          report_mismatch("pop_value", got_result.pop_value, want_result.pop_value);
        case (want_result.status)
          ksq_pkg::ST_OK:   n_ok++;
          ksq_pkg::ST_OVER: n_over++;
          default: n_under++;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    int phase_idle [4];
    int enq_pct, focus_q, q;
    phase_idle = '{0, 86, 0, 7};
    clear_queues();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty dequeue, extremes on every queue, drain, fill to overflow
    add_op(ksq_pkg::ACT_DEQ, 0, 32'h1234_5678);
    add_op(ksq_pkg::ACT_ENQ, 0, 32'h7FFF_FFFF);
    add_op(ksq_pkg::ACT_ENQ, 1, 32'h8000_0000);
    add_op(ksq_pkg::ACT_ENQ, 2, 32'h0000_0000);
    add_op(ksq_pkg::ACT_ENQ, 3, 32'hFFFF_FFFF);
    add_op(ksq_pkg::ACT_DEQ, 3, 32'hFFFF_FFFF);
    add_op(ksq_pkg::ACT_DEQ, 3, 32'h0);
    for (int i = 0; i < 13; i++)
      add_op(ksq_pkg::ACT_ENQ, 3, (i % 2) ? 32'h5555_5555 : 32'hAAAA_AAAA);
    add_op(ksq_pkg::ACT_ENQ, 1, 32'hDEAD_BEEF);
    add_op(ksq_pkg::ACT_DEQ, 0, 32'h0);
    add_op(ksq_pkg::ACT_DEQ, 1, 32'h0);
    add_op(ksq_pkg::ACT_DEQ, 2, 32'h0);
    drain_all();

    // random phases; the receiver cannot stall, and the first and third (idle 0) run at full rate
    for (int p = 0; p < 4; p++) begin
      idle_pct = phase_idle[p];
      enq_pct = 50;
      focus_q = 0;
      for (int i = 0; i < PHASE_WORDS; i++) begin
        if (i % 32 == 0) begin
          enq_pct = $urandom_range(15, 85);
          focus_q = $urandom_range(QUEUES - 1);
        end
        q = $urandom_range(1) ? focus_q : $urandom_range(QUEUES - 1);
        add_op(($urandom_range(99) < enq_pct) ? ksq_pkg::ACT_ENQ : ksq_pkg::ACT_DEQ, q,
               pick_word());
      end
      drain_all();
    end
    idle_pct = 0;

    repeat (4) @(negedge clk);
    if (expected_results.size() != 0)
      report_mismatch("results never arrived", DATA_W'(expected_results.size()), '0);
    $display("%0d words over directed and four random phases (idle 0/86/0/7 pct)",
             words_taken);
    $display("results: %0d ok, %0d overflow, %0d underflow; %0d errors",
             n_ok, n_over, n_under, errors);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### sim.f
rtl/ksq_pkg.sv
rtl/ksq_store.sv
rtl/k_queues_shared_buffer.sv
tb/sv/testbench.sv
